// ===== hdl/adc_pkg.sv =====
// Anchor drift detector shared definitions: types, constants, CORDIC angle table.
// No dependencies; imported by adc_cordic and anchor_drift_detector.
package adc_pkg;

  localparam int COORD_FRAC_BITS = 23;
  localparam int HALF_SH         = 31 - COORD_FRAC_BITS;
  localparam int FULL_SH         = HALF_SH + 1;
  localparam int CW              = 34;
  localparam int PW              = 2 * CW;
  localparam int CORDIC_STEPS    = 30;
  localparam int SQ_STEPS        = 32;

  // degrees to turns: divide by 360 = 45 << 3, base-2^20 digits by reciprocal multiply
  localparam int DEG_SH          = 3;
  localparam int DIV_CHUNK       = 20;
  localparam int DIV_STEPS       = (33 + FULL_SH - DEG_SH + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int DVD_W           = DIV_STEPS * DIV_CHUNK;
  localparam int DIV_NUM_W       = DIV_CHUNK + 6;
  localparam int DIV_PROD_W      = DIV_NUM_W + 27;
  localparam int DIV_RSH         = 32;

  localparam logic [5:0]           DIV_BASE        = 6'd45;
  localparam logic [26:0]          DIV_RECIP       = 27'd95443718;
  localparam logic signed [CW-1:0] CORDIC_GAIN     = 34'sd652032874;
  localparam logic signed [CW-1:0] DIST_SCALE      = 34'sd8006034718;
  localparam logic [31:0]          ANCHOR_MIN_TIME = 32'd1000000000;
  localparam logic [7:0]           COUNT_LIMIT     = 8'd255;
  localparam logic [15:0]          THR_RESET       = 16'd50;

  localparam logic ACT_SET   = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DLD, ST_DIV, ST_RLD, ST_ROT, ST_RST,
    ST_MUL, ST_ACC, ST_SQLD, ST_SQRT, ST_SQST, ST_VEC, ST_DONE
  } state_t;

  typedef enum logic [1:0] {KIND_SET, KIND_CLEAR, KIND_CHECK} kind_t;

  typedef struct packed {
    logic       load;
    logic       run;
    logic       vec;
    logic [4:0] step;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0:  atan_turn = 32'h20000000;
      5'd1:  atan_turn = 32'h12E4051E;
      5'd2:  atan_turn = 32'h09FB385B;
      5'd3:  atan_turn = 32'h051111D4;
      5'd4:  atan_turn = 32'h028B0D43;
      5'd5:  atan_turn = 32'h0145D7E1;
      5'd6:  atan_turn = 32'h00A2F61E;
      5'd7:  atan_turn = 32'h00517C55;
      5'd8:  atan_turn = 32'h0028BE53;
      5'd9:  atan_turn = 32'h00145F2F;
      5'd10: atan_turn = 32'h000A2F98;
      5'd11: atan_turn = 32'h000517CC;
      5'd12: atan_turn = 32'h00028BE6;
      5'd13: atan_turn = 32'h000145F3;
      5'd14: atan_turn = 32'h0000A2FA;
      5'd15: atan_turn = 32'h0000517D;
      5'd16: atan_turn = 32'h000028BE;
      5'd17: atan_turn = 32'h0000145F;
      5'd18: atan_turn = 32'h00000A30;
      5'd19: atan_turn = 32'h00000518;
      5'd20: atan_turn = 32'h0000028C;
      5'd21: atan_turn = 32'h00000146;
      5'd22: atan_turn = 32'h000000A3;
      5'd23: atan_turn = 32'h00000051;
      5'd24: atan_turn = 32'h00000029;
      5'd25: atan_turn = 32'h00000014;
      5'd26: atan_turn = 32'h0000000A;
      5'd27: atan_turn = 32'h00000005;
      5'd28: atan_turn = 32'h00000003;
      5'd29: atan_turn = 32'h00000001;
      default: atan_turn = 32'h00000000;
    endcase
  endfunction

endpackage

// ===== hdl/adc_cordic.sv =====
// Shared CORDIC shift-add step unit, rotation and vectoring mode, one step per cycle while run is set.
// Depends on adc_pkg (widths, angle table, control struct).
module adc_cordic import adc_pkg::*; (
  input  logic                 clk,
  input  cordic_ctl_t          ctl,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] z_in,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic signed [CW-1:0] z
);

  logic signed [CW-1:0] xs, ys, at;
  logic                 pos;

  always_comb begin
    xs  = x >>> ctl.step;
    ys  = y >>> ctl.step;
    at  = $signed({{(CW-32){1'b0}}, atan_turn(ctl.step)});
    pos = ctl.vec ? y[CW-1] : ~z[CW-1];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= x_in;
      y <= y_in;
      z <= z_in;
    end else if (ctl.run) begin
      if (pos) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

endmodule

// ===== hdl/anchor_drift_detector.sv =====
// Anchor drift detector top level: sequencer, divider, multiplier, square root, counters.
// Depends on adc_pkg and adc_cordic.
//
// channel  dir  beat contents (low bit first)
// s_axis   in   tdata: latitude[30:0] longitude[62:31] fix_epoch_s[94:63]; tuser: action
// m_axis   out  tdata: distance_cm[31:0] drift_detected[32] drift_count[40:33] anchor_valid[41]
// cfg      in   cfg_wdata: drift_threshold_m
//
// Set-anchor and no-anchor beats go straight to done; a check runs four angle divides and
// 30-step CORDIC rotations, two 32-step square roots, one 30-step vectoring pass and five
// multiplies on the shared units; vectoring and the fifth multiply need a nonzero haversine term.
// Input is taken only in idle. A finished result waits in the output register while
// the next beat is taken; it stalls the sequencer only at the end of the following beat.
// Synchronous reset clears control, anchor and counter and sets the threshold to 50 m.
module anchor_drift_detector import adc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // latitude, longitude, fix_epoch_s, zero pad
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // distance_cm, drift_detected, drift_count, anchor_valid, pad
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  state_t state, state_next;
  kind_t  kind;

  logic [15:0]        thr;
  logic signed [31:0] anchor_lat, anchor_lon;
  logic [31:0]        anchor_time;
  logic [7:0]         drift_counter, drift_counter_next;
  logic               drift_flag, drift_flag_next;

  logic signed [30:0] in_lat;
  logic signed [31:0] in_lon;
  logic [1:0]         job;
  logic [5:0]         cnt;
  logic [DVD_W-1:0]   dvd;
  logic [5:0]         rem;
  logic [31:0]        quo;
  logic               neg, fold;
  logic signed [CW-1:0] s1, s2, c1, c2, tq;
  logic [2:0]         mstep;
  logic signed [PW-1:0] prod;
  logic signed [62:0] acc;
  logic [60:0]        a_val, sv;
  logic [62:0]        sr, sbit;
  logic               sq_k;
  logic [30:0]        h;
  logic [31:0]        dist_cm;

  wire fire_in = s_axis_tvalid && s_axis_tready;
  wire done_go = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  wire av      = anchor_time > ANCHOR_MIN_TIME;

  assign s_axis_tready = (state == ST_IDLE);

  // angle source and divider step
  logic signed [32:0]    d_sel;
  logic [32:0]           mag;
  logic [DIV_NUM_W-1:0]  num;
  logic [DIV_PROD_W-1:0] qprod;
  logic [DIV_CHUNK-1:0]  qd;
  logic [5:0]            rem_n;
  logic [31:0]           turn, turn_f;

  always_comb begin
    unique case (job)
      2'd0:    d_sel = 33'(anchor_lat) - 33'(in_lat);
      2'd1:    d_sel = 33'(anchor_lon) - 33'(in_lon);
      2'd2:    d_sel = 33'(in_lat);
      default: d_sel = 33'(anchor_lat);
    endcase
    mag    = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
    num    = {rem, dvd[DVD_W-1 -: DIV_CHUNK]};
    qprod  = DIV_PROD_W'(num) * DIV_PROD_W'(DIV_RECIP);
    qd     = qprod[DIV_RSH +: DIV_CHUNK];
    rem_n  = 6'(num - DIV_NUM_W'(qd) * DIV_NUM_W'(DIV_BASE));
    turn   = neg ? (~quo + 32'd1) : quo;
    turn_f = {turn[31] ^ (turn[31] ^ turn[30]), turn[30:0]};
  end

  // shared CORDIC
  cordic_ctl_t          cctl;
  logic signed [CW-1:0] cx, cy, cz, cx_in, cy_in, cz_in, xo, yo, zc;

  always_comb begin
    cctl.load = (state == ST_RLD) || ((state == ST_SQST) && sq_k && (h != '0));
    cctl.run  = (state == ST_ROT) || (state == ST_VEC);
    cctl.vec  = (state == ST_VEC);
    cctl.step = cnt[4:0];
    if (state == ST_RLD) begin
      cx_in = CORDIC_GAIN;
      cy_in = '0;
      cz_in = $signed({{(CW-32){turn_f[31]}}, turn_f});
    end else begin
      cx_in = $signed({{(CW-31){1'b0}}, sr[30:0]});
      cy_in = $signed({{(CW-31){1'b0}}, h});
      cz_in = '0;
    end
    xo = fold ? -cx : cx;
    yo = fold ? -cy : cy;
    if (cz[CW-1])
      zc = '0;
    else if (cz > $signed(CW'(1) <<< 30))
      zc = $signed(CW'(1) <<< 30);
    else
      zc = cz;
  end

  adc_cordic u_cordic (
    .clk  (clk),
    .ctl  (cctl),
    .x_in (cx_in),
    .y_in (cy_in),
    .z_in (cz_in),
    .x    (cx),
    .y    (cy),
    .z    (cz)
  );

  // shared multiplier
  logic signed [CW-1:0] ma, mb;
  logic signed [PW-1:0] mres;
  logic signed [62:0]   asum;
  logic [60:0]          a_cl;
  logic [PW-1:0]        rnd;

  always_comb begin
    case (mstep)
      3'd0:    begin ma = c1; mb = c2; end
      3'd1:    begin ma = tq; mb = s2; end
      3'd2:    begin ma = s1; mb = s1; end
      3'd3:    begin ma = tq; mb = s2; end
      default: begin ma = zc; mb = DIST_SCALE; end
    endcase
    mres = ma * mb;
    asum = acc + prod[62:0];
    if (asum[62])
      a_cl = '0;
    else if (asum > (63'sd1 <<< 60))
      a_cl = 61'd1 << 60;
    else
      a_cl = asum[60:0];
    rnd = prod + (PW'(1) << 31);
  end

  // square root step
  logic [62:0] sq_sum;
  logic        sq_ge;
  assign sq_sum = sr + sbit;
  assign sq_ge  = {2'b0, sv} >= sq_sum;

  // drift state update
  logic [22:0] thr_cm;
  always_comb begin
    thr_cm = {1'b0, thr, 6'b0} + {2'b0, thr, 5'b0} + {5'b0, thr, 2'b0};
    drift_counter_next = drift_counter;
    drift_flag_next    = drift_flag;
    case (kind)
      KIND_CLEAR: begin
        drift_counter_next = '0;
        drift_flag_next    = 1'b0;
      end
      KIND_CHECK: begin
        if (dist_cm > 32'(thr_cm)) begin
          if (drift_counter < COUNT_LIMIT) drift_counter_next = drift_counter + 8'd1;
          drift_flag_next = 1'b1;
        end else begin
          drift_counter_next = '0;
          drift_flag_next    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (fire_in)
        state_next = (s_axis_tuser == ACT_CHECK && av) ? ST_DLD : ST_DONE;
      ST_DLD:  state_next = ST_DIV;
      ST_DIV:  if (cnt == 6'(DIV_STEPS - 1)) state_next = ST_RLD;
      ST_RLD:  state_next = ST_ROT;
      ST_ROT:  if (cnt == 6'(CORDIC_STEPS - 1)) state_next = ST_RST;
      ST_RST:  state_next = (job == 2'd3) ? ST_MUL : ST_DLD;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC: begin
        if (mstep == 3'd3)      state_next = ST_SQLD;
        else if (mstep == 3'd4) state_next = ST_DONE;
        else                    state_next = ST_MUL;
      end
      ST_SQLD: state_next = ST_SQRT;
      ST_SQRT: if (cnt == 6'(SQ_STEPS - 1)) state_next = ST_SQST;
      ST_SQST: begin
        if (!sq_k)          state_next = ST_SQLD;
        else if (h == '0)   state_next = ST_DONE;
        else                state_next = ST_VEC;
      end
      ST_VEC:  if (cnt == 6'(CORDIC_STEPS - 1)) state_next = ST_MUL;
      ST_DONE: if (done_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr           <= THR_RESET;
      anchor_lat    <= '0;
      anchor_lon    <= '0;
      anchor_time   <= '0;
      drift_counter <= '0;
      drift_flag    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      if (fire_in && s_axis_tuser == ACT_SET) begin
        anchor_lat  <= 32'(signed'(s_axis_tdata[30:0]));
        anchor_lon  <= s_axis_tdata[62:31];
        anchor_time <= s_axis_tdata[94:63];
      end
      if (done_go) begin
        drift_counter <= drift_counter_next;
        drift_flag    <= drift_flag_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (done_go)
      m_axis_tdata <= {6'b0, av, drift_counter_next, drift_flag_next, dist_cm};
    unique case (state)
      ST_IDLE: begin
        in_lat  <= s_axis_tdata[30:0];
        in_lon  <= s_axis_tdata[62:31];
        job     <= 2'd0;
        mstep   <= 3'd0;
        sq_k    <= 1'b0;
        dist_cm <= '0;
        if (s_axis_tuser == ACT_SET) kind <= KIND_SET;
        else if (av)                 kind <= KIND_CHECK;
        else                         kind <= KIND_CLEAR;
      end
      ST_DLD: begin
        dvd <= DVD_W'(mag) << ((job[1] ? FULL_SH : HALF_SH) - DEG_SH);
        neg <= d_sel[32];
        rem <= '0;
        cnt <= '0;
      end
      ST_DIV: begin
        rem <= rem_n;
        quo <= 32'({quo, qd});
        dvd <= dvd << DIV_CHUNK;
        cnt <= cnt + 6'd1;
      end
      ST_RLD: begin
        fold <= turn[31] ^ turn[30];
        cnt  <= '0;
      end
      ST_ROT: cnt <= cnt + 6'd1;
      ST_RST: begin
        case (job)
          2'd0:    s1 <= yo;
          2'd1:    s2 <= yo;
          2'd2:    c1 <= xo;
          default: c2 <= xo;
        endcase
        job <= job + 2'd1;
      end
      ST_MUL: prod <= mres;
      ST_ACC: begin
        case (mstep)
          3'd0, 3'd1: tq <= prod[CW+29:30];
          3'd2:       acc <= prod[62:0];
          3'd3:       a_val <= a_cl;
          default:    dist_cm <= (|rnd[PW-1:64]) ? 32'hFFFFFFFF : rnd[63:32];
        endcase
        mstep <= mstep + 3'd1;
      end
      ST_SQLD: begin
        sv   <= sq_k ? (61'd1 << 60) - a_val : a_val;
        sr   <= '0;
        sbit <= 63'd1 << 62;
        cnt  <= '0;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sv <= 61'({2'b0, sv} - sq_sum);
          sr <= (sr >> 1) + sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
        cnt  <= cnt + 6'd1;
      end
      ST_SQST: begin
        if (!sq_k) h <= sr[30:0];
        sq_k <= 1'b1;
        cnt  <= '0;
      end
      ST_VEC: cnt <= cnt + 6'd1;
      ST_DONE: ;
      default: ;
    endcase
  end

  a_count_flag: assert property (@(posedge clk) disable iff (rst)
    (drift_counter != 8'd0) == drift_flag)
    else $error("drift counter and flag disagree");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    fire_in |=> !s_axis_tready)
    else $error("input taken twice in a row");

  a_dist_needs_anchor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[31:0] != 32'd0) |-> m_axis_tdata[41])
    else $error("distance reported without anchor");

  a_flag_needs_anchor: assert property (@(posedge clk) disable iff (rst)
    done_go && kind == KIND_CHECK |-> av)
    else $error("check finished without anchor");

endmodule
